>>> design/hls_pkg.sv
// shared constants, types and command/status structs for the hyperloglog sketch unit
// no dependencies; imported by hls_ctrl, hls_datapath, hyperloglog_sketch_unit and the testbench
`default_nettype none
package hls_pkg;

  localparam int PRECISION = 14;
  localparam int NREG      = 1 << PRECISION;
  localparam int RMAX      = 65 - PRECISION;
  localparam int HASH_W    = 64;
  localparam int RANK_W    = 6;
  localparam int WBITS     = HASH_W - PRECISION;
  localparam int ACC_W     = 66;
  localparam int QUO_W     = 64;
  localparam int DIVD_W    = 128;
  localparam int BIDX_W    = 7;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // alpha with 16 fraction bits, rounded half up
  localparam longint unsigned ALPHA_NUM =
      (NREG == 16) ? 64'd673 : (NREG == 32) ? 64'd697 : (NREG == 64) ? 64'd709 :
      64'(7213 * NREG);
  localparam longint unsigned ALPHA_DEN =
      (NREG <= 64) ? 64'd1000 : 64'(10 * (1000 * NREG + 1079));
  localparam longint unsigned ALPHA_FIX =
      (2 * ALPHA_NUM * 65536 + ALPHA_DEN) / (2 * ALPHA_DEN);

  // alpha * m * m * 2^rmax
  localparam logic [DIVD_W-1:0] DIVIDEND =
      DIVD_W'(ALPHA_FIX) << (2 * PRECISION + RMAX - 16);

  typedef struct packed {
    logic load_hash;  // capture accepted request, read its register
    logic clr_we;     // write zero at sweep address
    logic add_wr;     // max update of the captured register
    logic cnt_clr;    // sweep address and accumulator back to zero
    logic cnt_inc;    // next sweep address
    logic sum_rd;     // read at sweep address for the sum
    logic div_init;   // start the divider
    logic div_step;   // one quotient bit
    logic out_load;   // move quotient to the output register
  } hls_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic div_last;
    logic out_busy;
  } hls_sts_t;

endpackage
`default_nettype wire

>>> design/hls_ctrl.sv
// controller state machine of the hyperloglog sketch unit
// depends on hls_pkg
`default_nettype none
module hls_ctrl
  import hls_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_mode,
  output logic          in_ready,
  output hls_cmd_t      cmd,
  input  wire hls_sts_t sts
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_ADD, ST_SUM, ST_SUM_END, ST_DIV, ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_we  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_hash = 1'b1;
          if (in_mode == MODE_QUERY) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = ST_SUM;
          end else begin
            state_nxt   = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        cmd.add_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SUM: begin
        cmd.sum_rd  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) state_nxt = ST_SUM_END;
      end
      ST_SUM_END: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_clear_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_ready) else $error("ready during clearing pass");
  a_div_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && sts.div_last) |=> state_r == ST_DONE)
    else $error("divider end not followed by result");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy) else $error("result overwrites pending result");
  a_add_short: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ADD |=> in_ready) else $error("add took more than two cycles");

endmodule
`default_nettype wire

>>> design/hls_datapath.sv
// datapath: rank memory, rank encoder, sum accumulator, bit-serial divider, output register
// depends on hls_pkg
`default_nettype none
module hls_datapath
  import hls_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hls_cmd_t          cmd,
  output hls_sts_t               sts,
  input  wire logic [HASH_W-1:0] in_hash,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [QUO_W-1:0]       out_estimate
);

  logic [RANK_W-1:0]    mem [NREG];
  logic [RANK_W-1:0]    rd_data_r;
  logic [PRECISION-1:0] addr_r, rd_addr;
  logic [HASH_W-1:0]    hash_r;
  logic                 acc_pend_r;
  logic [ACC_W-1:0]     acc_r;
  logic [ACC_W:0]       rem_r, rem_sh;
  logic [QUO_W-1:0]     q_r;
  logic                 ovf_r;
  logic [BIDX_W-1:0]    bidx_r;
  logic                 out_valid_r;
  logic [QUO_W-1:0]     out_data_r;
  logic [RANK_W-1:0]    rank, rank_cap;
  logic [WBITS-1:0]     w;
  logic [ACC_W-1:0]     term;

  // rank = leading zeros of the low bits plus one, rmax when they are zero
  always_comb begin
    w    = hash_r[WBITS-1:0];
    rank = RANK_W'(RMAX);
    for (int i = 0; i < WBITS; i++) begin
      if (w[i]) rank = RANK_W'(WBITS - i);
    end
  end

  assign rd_addr  = cmd.load_hash ? in_hash[HASH_W-1 -: PRECISION] : addr_r;
  assign rank_cap = (rd_data_r > RANK_W'(RMAX)) ? RANK_W'(RMAX) : rd_data_r;
  assign term     = ACC_W'(1) << (RANK_W'(RMAX) - rank_cap);
  assign rem_sh   = {rem_r[ACC_W-1:0], DIVIDEND[bidx_r]};

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (cmd.clr_we) begin
      mem[addr_r] <= '0;
    end else if (cmd.add_wr && rank > rd_data_r) begin
      mem[hash_r[HASH_W-1 -: PRECISION]] <= rank;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      acc_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_pend_r <= cmd.sum_rd;
      if (cmd.cnt_clr) begin
        addr_r <= '0;
      end else if (cmd.cnt_inc) begin
        addr_r <= addr_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_hash) hash_r <= in_hash;
    if (cmd.cnt_clr) begin
      acc_r <= '0;
    end else if (acc_pend_r) begin
      acc_r <= acc_r + term;
    end
    if (cmd.div_init) begin
      rem_r  <= '0;
      q_r    <= '0;
      ovf_r  <= 1'b0;
      bidx_r <= BIDX_W'(DIVD_W - 1);
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, acc_r}) begin
        rem_r <= rem_sh - {1'b0, acc_r};
        q_r   <= {q_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r   <= {q_r[QUO_W-2:0], 1'b0};
      end
      ovf_r  <= ovf_r | q_r[QUO_W-1];
      bidx_r <= bidx_r - 1'b1;
    end
    if (cmd.out_load) out_data_r <= ovf_r ? '1 : q_r;
  end

  assign sts.cnt_last = (addr_r == '1);
  assign sts.div_last = (bidx_r == '0);
  assign sts.out_busy = out_valid_r;
  assign out_valid    = out_valid_r;
  assign out_estimate = out_data_r;

endmodule
`default_nettype wire

>>> design/hyperloglog_sketch_unit.sv
// top level of the hyperloglog cardinality sketch
// depends on hls_pkg, hls_ctrl, hls_datapath
//
// input stream: in_tuser is the mode (0 add, 1 query), in_tdata the 64-bit hash.
// an add request first reads the selected rank register from the rank memory,
// then writes back the larger rank; it yields no result.
// a query request sweeps all 2^PRECISION registers through the memory read port,
// one per cycle, then runs a restoring divider one quotient bit per cycle over
// 128 bits.
// the result is the raw estimate floor(alpha*m*m/sum(2^-rank)) saturated to 64 bits,
// presented on the output stream from an output register.
// after reset the rank memory is swept to zero one entry a cycle, with in_tready low.
// a stalled receiver does not block adds unless a query result waits for it; a query
// whose result is ready waits until the previous result has been taken.
`default_nettype none
module hyperloglog_sketch_unit
  import hls_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [HASH_W-1:0] in_tdata,   // [63:0] hash
  input  wire logic              in_tuser,   // [0] mode
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [QUO_W-1:0]       out_tdata   // [63:0] estimate
);

  hls_cmd_t cmd;
  hls_sts_t sts;

  hls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_mode  (in_tuser),
    .in_ready (in_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  hls_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_hash      (in_tdata),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_estimate (out_tdata)
  );

endmodule
`default_nettype wire

>>> dv/hyperloglog_sketch_unit_tb.sv
// self-checking testbench for the hyperloglog sketch unit
// depends on hls_pkg and the hyperloglog_sketch_unit rtl
`timescale 1ns / 1ps
`default_nettype none
module hyperloglog_sketch_unit_tb;
  import hls_pkg::*;

  typedef struct {
    logic              mode;
    logic [HASH_W-1:0] hash;
    bit                drain;  // hold off until all estimates are back
    bit                calm;   // from here on no idling on either side
  } sketch_req_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [HASH_W-1:0] in_tdata = '0;
  logic              in_tuser = MODE_ADD;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [QUO_W-1:0]  out_tdata;

  hyperloglog_sketch_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sketch_req_t        pend_q[$];
  logic [QUO_W-1:0]   estimate_q[$];
  logic [RANK_W-1:0]  rank_mem[NREG];
  sketch_req_t        cur_req;
  bit                 quiet = 1'b0;
  int                 src_gap = 0;
  int                 sink_gap = 0;
  int                 err_cnt = 0;
  int                 add_cnt = 0;
  int                 query_cnt = 0;
  int                 idle_cycles = 0;
  longint unsigned    alpha_fix;

  // alpha with 16 fraction bits, rounded half up
  function automatic longint unsigned calc_alpha();
    longint unsigned m, num, den;
    m = NREG;
    if (m == 16) begin
      num = 673; den = 1000;
    end else if (m == 32) begin
      num = 697; den = 1000;
    end else if (m == 64) begin
      num = 709; den = 1000;
    end else begin
      num = 7213 * m; den = 10 * (1000 * m + 1079);
    end
    return (2 * num * 65536 + den) / (2 * den);
  endfunction

  // leading zeros of the remainder bits plus one; all-zero remainder gives rmax
  function automatic int rank_of(logic [HASH_W-1:0] h);
    int n;
    n = 0;
    if (h[WBITS-1:0] == '0) return RMAX;
    while (!h[WBITS-1-n]) n++;
    return n + 1;
  endfunction

  function automatic logic [QUO_W-1:0] estimate_of();
    logic [ACC_W-1:0]  sum;
    logic [DIVD_W-1:0] divd, quo;
    int r;
    sum = '0;
    for (int i = 0; i < NREG; i++) begin
      r = rank_mem[i];
      if (r > RMAX) r = RMAX;
      sum += ACC_W'(1) << (RMAX - r);
    end
    divd = DIVD_W'(alpha_fix * NREG * NREG) << (RMAX - 16);
    quo = divd / DIVD_W'(sum);
    if (quo[DIVD_W-1:QUO_W] != '0) return '1;
    return quo[QUO_W-1:0];
  endfunction

  task automatic update_sketch(sketch_req_t rq);
    logic [PRECISION-1:0] idx;
    int r;
    if (rq.mode == MODE_QUERY) begin
      estimate_q.push_back(estimate_of());
      query_cnt++;
    end else begin
      idx = rq.hash[HASH_W-1 -: PRECISION];
      r = rank_of(rq.hash);
      if (r > rank_mem[idx]) rank_mem[idx] = RANK_W'(r);
      add_cnt++;
    end
  endtask

  // driver: presents pending requests with random gaps
  always @(posedge clk) begin
    bit nv;
    bit held;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      held = in_tvalid && !in_tready;
      if (in_tvalid && in_tready) update_sketch(cur_req);
      if (!held) begin
        nv = 1'b0;
        if (src_gap > 0) begin
          src_gap--;
        end else if (pend_q.size() > 0 && !(pend_q[0].drain && estimate_q.size() != 0)) begin
          cur_req = pend_q.pop_front();
          if (cur_req.calm) quiet = 1'b1;
          in_tdata <= cur_req.hash;
          in_tuser <= cur_req.mode;
          nv = 1'b1;
          if (!quiet && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 9);
        end
        in_tvalid <= nv;
      end
    end
  end

  // monitor: random backpressure, compare each estimate with the oldest prediction
  always @(posedge clk) begin
    logic [QUO_W-1:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (estimate_q.size() == 0) begin
          $error("estimate with no request pending: actual %0d", out_tdata);
          err_cnt++;
        end else begin
          want = estimate_q.pop_front();
          if (out_tdata !== want) begin
            $error("estimate mismatch: expected %0d actual %0d", want, out_tdata);
            err_cnt++;
          end
        end
      end
      if (quiet) begin
        out_tready <= 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) sink_gap = $urandom_range(1, 9);
      end
    end
  end

  // watchdog: reset clear and a full query walk are the longest quiet stretches
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 100000) begin
      $display("timeout after %0d cycles with no request moving", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic push_req(logic md, logic [HASH_W-1:0] h, bit dr = 0, bit cm = 0);
    sketch_req_t rq;
    rq.mode = md; rq.hash = h; rq.drain = dr; rq.calm = cm;
    pend_q.push_back(rq);
  endtask

  function automatic logic [HASH_W-1:0] random_hash();
    logic [HASH_W-1:0] h;
    logic [WBITS-1:0]  w;
    h = {$urandom, $urandom};
    w = h[WBITS-1:0] >> $urandom_range(0, WBITS);
    case ($urandom_range(0, 3))
      0: return h;
      1: return {PRECISION'($urandom_range(0, 7)), w};
      2: return {h[HASH_W-1 -: PRECISION], WBITS'(0)};
      default: return {h[HASH_W-1 -: PRECISION], w};
    endcase
  endfunction

  initial begin
    int n_add, n_query;
    alpha_fix = calc_alpha();
    foreach (rank_mem[i]) rank_mem[i] = '0;

    // directed: empty sketch, field extremes, zero remainder, hash ignored on query
    push_req(MODE_QUERY, '0);
    push_req(MODE_QUERY, '1);
    push_req(MODE_ADD, '1);
    push_req(MODE_ADD, '0);
    push_req(MODE_ADD, {PRECISION'(0), WBITS'(1)});
    push_req(MODE_ADD, {{PRECISION{1'b1}}, WBITS'(1)});
    push_req(MODE_ADD, {PRECISION'(5), WBITS'(0)});
    push_req(MODE_ADD, {PRECISION'(5), WBITS'(1)});  // smaller rank must not win
    push_req(MODE_ADD, {PRECISION'(6), 1'b1, {(WBITS-1){1'b0}}});
    push_req(MODE_QUERY, 64'h5555_5555_5555_5555);
    push_req(MODE_ADD, 64'haaaa_aaaa_aaaa_aaaa);
    push_req(MODE_ADD, 64'h5555_5555_5555_5555);
    push_req(MODE_QUERY, '0, 1);

    // random: mostly adds, a query now and then
    n_add = 0; n_query = 0;
    while (n_add < 1050 || n_query < 30) begin
      if ($urandom_range(0, 33) == 0) begin
        push_req(MODE_QUERY, {$urandom, $urandom}, $urandom_range(0, 7) == 0);
        n_query++;
      end else begin
        push_req(MODE_ADD, random_hash());
        n_add++;
      end
    end

    // top rank on a spread of registers, then query, with no idling
    for (int i = 0; i < 64; i++)
      push_req(MODE_ADD, {PRECISION'(i * 97), WBITS'(0)}, 0, i == 0);
    push_req(MODE_QUERY, '0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (pend_q.size() == 0 && !in_tvalid);
    wait (estimate_q.size() == 0);
    repeat (200) @(posedge clk);
    if (estimate_q.size() != 0) begin
      $error("%0d estimates never came out", estimate_q.size());
      err_cnt++;
    end
    $display("covered %0d hash adds and %0d estimate queries, from empty sketch to top ranks",
             add_cnt, query_cnt);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
